// ===== hdl/bitmap_id_allocator_macros.svh =====
// Assertion macros shared by the identifier allocator RTL.
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BIA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define BIA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define BIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bia_pkg.sv =====
// Package with the types and constants of the identifier allocator.
package bia_pkg;

    localparam int WORD_BITS = 32;
    localparam int OFF_BITS  = 5;
    localparam int ID_W      = 16;
    localparam int MODE_W    = 3;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC     = 3'd0,
        MODE_RELEASE   = 3'd1,
        MODE_MARK      = 3'd2,
        MODE_QUERY     = 3'd3,
        MODE_CLEAR_ALL = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                found;
        logic [OFF_BITS-1:0] idx;
    } t_scan_res;

endpackage

// ===== hdl/bia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bia_scan.sv =====
// Search unit that finds the lowest free bit of a bitmap word at or above a start offset.
module bia_scan (
    input  logic [bia_pkg::WORD_BITS-1:0] i_word,
    input  logic [bia_pkg::OFF_BITS-1:0]  i_start,
    output bia_pkg::t_scan_res            o_res
);
    import bia_pkg::*;

    logic [WORD_BITS-1:0] below_mask;
    logic [WORD_BITS-1:0] free_bits;

    assign below_mask = (WORD_BITS'(1) << i_start) - WORD_BITS'(1);
    assign free_bits  = ~(i_word | below_mask);

    always_comb begin
        o_res.found = |free_bits;
        o_res.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                o_res.idx = OFF_BITS'(i);
            end
        end
    end

endmodule

// ===== hdl/bitmap_id_allocator.sv =====
// Top level of the bitmap next-fit identifier allocator.
//
// One command word enters on the slave stream: tuser carries the mode
// (allocate, release, mark used, query, clear all) and tdata the identifier.
// Exactly one result word leaves on the master stream for every command.
// A release, mark or query goes from acceptance through a RAM read state and
// an evaluate state to the hand-off state, which loads the result register;
// no new command is accepted before that load, and the next is taken in the
// cycle after it. An allocate reads and searches bitmap words in turn until a
// free bit is found (usually in the first word, at most 2^(ID_BITS-5) + 1
// words); each word costs one RAM read and one pass through the shared search
// unit. A full map or an undefined mode goes from acceptance straight to the
// hand-off. Clear all sweeps the bitmap RAM one word per cycle and then
// answers. Reset starts the same sweep, during which no command is accepted.
// The result sits in an output register, so the next command is accepted while
// a result waits; a stalled receiver keeps the following result, and with it
// the input, waiting until the held word leaves.
module bitmap_id_allocator #(
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [15:0] id_value
    input  logic [2:0]  i_s_tuser,  // [2:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // [15:0] result_id, [16] in_use, [17] full_res
);
    import bia_pkg::*;

    `include "bitmap_id_allocator_macros.svh"

    localparam int WA = ID_BITS - OFF_BITS;

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [WA-1:0]         r_word, n_word;
    logic [OFF_BITS-1:0]   r_off, n_off;
    logic [ID_BITS-1:0]    r_next_id, n_next_id;
    logic [ID_BITS:0]      r_used_cnt, n_used_cnt;
    logic [WA-1:0]         r_clr_addr, n_clr_addr;
    logic                  r_clr_cmd, n_clr_cmd;
    logic [ID_W-1:0]       r_res_id, n_res_id;
    logic                  r_res_in_use, n_res_in_use;
    logic                  r_res_full, n_res_full;
    logic                  r_out_valid, n_out_valid;
    logic [ID_W-1:0]       r_out_id, n_out_id;
    logic                  r_out_in_use, n_out_in_use;
    logic                  r_out_full, n_out_full;

    logic                  ram_we;
    logic [WA-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [WA-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [ID_BITS+ID_W-1:0] in_ext;
    logic [ID_BITS-1:0]      in_id;
    logic [ID_BITS-1:0]      cand_id;
    logic [ID_BITS-1:0]      cur_id;
    logic [ID_BITS-1:0]      found_id;
    logic [ID_BITS+ID_W-1:0] found_ext;
    logic                    cur_bit;
    t_scan_res               scan_res;

    assign in_ext    = {{ID_BITS{1'b0}}, i_s_tdata};
    assign in_id     = in_ext[ID_BITS-1:0];
    assign cand_id   = r_next_id + ID_BITS'(1);
    assign cur_id    = {r_word, r_off};
    assign found_id  = {r_word, scan_res.idx};
    assign found_ext = {{ID_W{1'b0}}, found_id};
    assign cur_bit   = ram_rdata[r_off];

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (1 << WA)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bia_scan u_scan (
        .i_word  (ram_rdata),
        .i_start (r_off),
        .o_res   (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_cmd   <= 1'b0;
            r_next_id   <= '0;
            r_used_cnt  <= (ID_BITS + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_cmd   <= n_clr_cmd;
            r_next_id   <= n_next_id;
            r_used_cnt  <= n_used_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_word       <= n_word;
        r_off        <= n_off;
        r_res_id     <= n_res_id;
        r_res_in_use <= n_res_in_use;
        r_res_full   <= n_res_full;
        r_out_id     <= n_out_id;
        r_out_in_use <= n_out_in_use;
        r_out_full   <= n_out_full;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_word       = r_word;
        n_off        = r_off;
        n_next_id    = r_next_id;
        n_used_cnt   = r_used_cnt;
        n_clr_addr   = r_clr_addr;
        n_clr_cmd    = r_clr_cmd;
        n_res_id     = r_res_id;
        n_res_in_use = r_res_in_use;
        n_res_full   = r_res_full;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_id     = r_out_id;
        n_out_in_use = r_out_in_use;
        n_out_full   = r_out_full;
        ram_we       = 1'b0;
        ram_waddr    = r_word;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_word;
        o_s_tready   = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = (r_clr_addr == '0) ? WORD_BITS'(1) : '0;
                n_clr_addr = r_clr_addr + WA'(1);
                if (&r_clr_addr) begin
                    n_clr_addr = '0;
                    n_clr_cmd  = 1'b0;
                    n_state    = r_clr_cmd ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_mode       = i_s_tuser;
                    n_res_id     = i_s_tdata;
                    n_res_in_use = 1'b0;
                    n_res_full   = 1'b0;
                    n_word       = in_id[ID_BITS-1:OFF_BITS];
                    n_off        = in_id[OFF_BITS-1:0];
                    case (i_s_tuser)
                        MODE_ALLOC: begin
                            if (r_used_cnt[ID_BITS]) begin
                                n_res_full = 1'b1;
                                n_res_id   = '0;
                                n_state    = ST_DONE;
                            end else begin
                                n_word  = cand_id[ID_BITS-1:OFF_BITS];
                                n_off   = cand_id[OFF_BITS-1:0];
                                n_state = ST_READ;
                            end
                        end
                        MODE_RELEASE, MODE_MARK, MODE_QUERY: begin
                            n_state = ST_READ;
                        end
                        MODE_CLEAR_ALL: begin
                            n_clr_addr = '0;
                            n_clr_cmd  = 1'b1;
                            n_used_cnt = (ID_BITS + 1)'(1);
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_DONE;
                case (r_mode)
                    MODE_ALLOC: begin
                        if (scan_res.found) begin
                            ram_we     = 1'b1;
                            ram_wdata  = ram_rdata | (WORD_BITS'(1) << scan_res.idx);
                            n_next_id  = found_id;
                            n_used_cnt = r_used_cnt + (ID_BITS + 1)'(1);
                            n_res_id   = found_ext[ID_W-1:0];
                        end else begin
                            n_word  = r_word + WA'(1);
                            n_off   = '0;
                            n_state = ST_READ;
                        end
                    end
                    MODE_RELEASE: begin
                        if (cur_bit && (cur_id != '0)) begin
                            ram_we     = 1'b1;
                            ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << r_off);
                            n_used_cnt = r_used_cnt - (ID_BITS + 1)'(1);
                        end
                    end
                    MODE_MARK: begin
                        if (!cur_bit) begin
                            ram_we     = 1'b1;
                            ram_wdata  = ram_rdata | (WORD_BITS'(1) << r_off);
                            n_used_cnt = r_used_cnt + (ID_BITS + 1)'(1);
                        end
                    end
                    MODE_QUERY: begin
                        n_res_in_use = cur_bit;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_in_use = r_res_in_use;
                    n_out_full   = r_res_full;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_full, r_out_in_use, r_out_id};

    `BIA_ASSERT_ALWAYS(a_count_bound,
        !(r_used_cnt[ID_BITS] && (|r_used_cnt[ID_BITS-1:0])),
        "used count beyond map size")
    `BIA_ASSERT_ALWAYS(a_count_nonzero, r_used_cnt != '0, "used count lost identifier zero")
    `BIA_ASSERT_IMPL(a_full_zero_id, o_m_tvalid && o_m_tdata[17],
        o_m_tdata[15:0] == 16'h0, "full result carries nonzero identifier")
    `BIA_ASSERT_ALWAYS(a_ram_ports, !(ram_we && ram_re),
        "bitmap read and write in the same cycle")
    `BIA_ASSERT_NEXT(a_alloc_marks,
        (r_state == ST_EVAL) && (r_mode == MODE_ALLOC) && scan_res.found,
        r_next_id != '0, "allocation handed out identifier zero")

endmodule

// ===== verif/id_alloc_checker.sv =====
// Checker that predicts and compares every result word of the identifier allocator.
`timescale 1ns / 1ps

module id_alloc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [bia_pkg::ID_W-1:0]         i_s_tdata,   // [15:0] id_value
    input  logic [bia_pkg::MODE_W-1:0]       i_s_tuser,   // [2:0] mode
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [bia_pkg::OUT_DATA_W-1:0]   i_m_tdata,   // [15:0] result_id, [16] in_use,
                                                          // [17] full_res
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_cmd_count,
    output int                               o_result_count,
    output int                               o_full_count,
    output int                               o_wrap_count
);
    import bia_pkg::*;

    localparam int MAP_WORDS   = 1 << (ID_W - OFF_BITS);
    localparam int ID_TOTAL    = 1 << ID_W;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic            full_res;
        logic            in_use;
        logic [ID_W-1:0] result_id;
    } t_answer;

    logic [WORD_BITS-1:0] id_map [MAP_WORDS];
    logic [ID_W-1:0]      last_handed;
    int unsigned          ids_taken;
    t_answer              answers_due [$];

    int fails = 0;
    int reported = 0;
    int pending = 0;
    int cmds = 0;
    int results = 0;
    int full_hits = 0;
    int wraps = 0;

    assign o_fail_count   = fails;
    assign o_pending      = pending;
    assign o_cmd_count    = cmds;
    assign o_result_count = results;
    assign o_full_count   = full_hits;
    assign o_wrap_count   = wraps;

    function automatic logic id_taken(input logic [ID_W-1:0] id);
        return id_map[id[ID_W-1:OFF_BITS]][id[OFF_BITS-1:0]];
    endfunction

    function automatic void put_id(input logic [ID_W-1:0] id, input logic val);
        if (id_taken(id) != val) begin
            id_map[id[ID_W-1:OFF_BITS]][id[OFF_BITS-1:0]] = val;
            if (val) begin
                ids_taken++;
            end else begin
                ids_taken--;
            end
        end
    endfunction

    function automatic void wipe_map();
        for (int w = 0; w < MAP_WORDS; w++) begin
            id_map[w] = '0;
        end
        id_map[0][0] = 1'b1;
        ids_taken = 1;
    endfunction

    function automatic t_answer run_command(input logic [MODE_W-1:0] mode,
                                            input logic [ID_W-1:0] id);
        t_answer         ans;
        logic [ID_W-1:0] cand;
        ans.result_id = id;
        ans.in_use    = 1'b0;
        ans.full_res  = 1'b0;
        case (mode)
            MODE_ALLOC: begin
                if (ids_taken >= ID_TOTAL) begin
                    ans.full_res  = 1'b1;
                    ans.result_id = '0;
                    full_hits++;
                end else begin
                    cand = last_handed;
                    do begin
                        cand = cand + 1'b1;
                    end while (id_taken(cand));
                    if (cand < last_handed) begin
                        wraps++;
                    end
                    last_handed = cand;
                    put_id(cand, 1'b1);
                    ans.result_id = cand;
                end
            end
            MODE_RELEASE: begin
                if (id != '0) begin
                    put_id(id, 1'b0);
                end
            end
            MODE_MARK: begin
                put_id(id, 1'b1);
            end
            MODE_QUERY: begin
                ans.in_use = id_taken(id);
            end
            MODE_CLEAR_ALL: begin
                wipe_map();
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer seen;
        t_answer due;
        if (!i_rst_n) begin
            wipe_map();
            last_handed = '0;
            answers_due.delete();
            pending = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results++;
                seen = t_answer'(i_m_tdata[17:0]);
                if (answers_due.size() == 0) begin
                    fails++;
                    if (reported < MAX_REPORTS) begin
                        $display("%0t: result word %h arrived with nothing expected",
                                 $realtime, i_m_tdata);
                    end
                    reported++;
                end else begin
                    due = answers_due.pop_front();
                    if (seen.result_id !== due.result_id || seen.in_use !== due.in_use
                            || seen.full_res !== due.full_res) begin
                        fails++;
                        if (reported < MAX_REPORTS) begin
                            $display({"%0t: expected id %h in_use %b full %b,",
                                      " got id %h in_use %b full %b"},
                                     $realtime, due.result_id, due.in_use, due.full_res,
                                     seen.result_id, seen.in_use, seen.full_res);
                        end
                        reported++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cmds++;
                answers_due.push_back(run_command(i_s_tuser, i_s_tdata));
            end
            pending = answers_due.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top that drives commands into the identifier allocator and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import bia_pkg::*;

    localparam int WATCHDOG_LIMIT = 25000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int ID_SPACE       = 1 << ID_W;
    localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [ID_W-1:0]       i_s_tdata;
    logic [MODE_W-1:0]     i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending;
    int cmd_count;
    int result_count;
    int full_count;
    int wrap_count;
    int idle_cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b1;
    logic [ID_W-1:0] focus;

    always #5 i_clk = ~i_clk;

    bitmap_id_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    id_alloc_checker u_alloc_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_cmd_count    (cmd_count),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_wrap_count   (wrap_count)
    );

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("No word moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= id;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 34) begin
            return MODE_ALLOC;
        end else if (r < 58) begin
            return MODE_RELEASE;
        end else if (r < 70) begin
            return MODE_MARK;
        end else if (r < 93) begin
            return MODE_QUERY;
        end else if (r < 94) begin
            return MODE_CLEAR_ALL;
        end
        case ($urandom_range(0, 2))
            0: return MODE_RSVD_5;
            1: return MODE_RSVD_6;
            default: return MODE_RSVD_7;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return base + ID_W'($urandom_range(0, 511));
        end else if (r < 7) begin
            case ($urandom_range(0, 7))
                0: return '0;
                1: return ID_W'(1);
                2: return '1;
                3: return ID_W'(ID_SPACE - 2);
                4: return ID_W'(ID_SPACE / 2);
                5: return ID_W'(ID_SPACE / 2 - 1);
                6: return ID_W'(WORD_BITS - 1);
                default: return ID_W'(WORD_BITS);
            endcase
        end
        return ID_W'($urandom());
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        focus      = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(MODE_QUERY, '0);
        issue(MODE_RELEASE, '0);
        issue(MODE_QUERY, '0);
        issue(MODE_ALLOC, '1);
        issue(MODE_ALLOC, '0);
        issue(MODE_QUERY, ID_W'(1));
        issue(MODE_RELEASE, ID_W'(1));
        issue(MODE_QUERY, ID_W'(1));
        issue(MODE_MARK, '1);
        issue(MODE_MARK, '1);
        issue(MODE_QUERY, '1);
        issue(MODE_RELEASE, ID_W'(3));
        issue(MODE_MARK, ID_W'(4));
        issue(MODE_ALLOC, '0);
        issue(MODE_ALLOC, '0);
        issue(MODE_RSVD_5, 16'hA5A5);
        issue(MODE_RSVD_6, 16'h5A5A);
        issue(MODE_RSVD_7, '1);
        issue(MODE_CLEAR_ALL, 16'h1234);
        issue(MODE_QUERY, ID_W'(2));
        issue(MODE_QUERY, '1);
        issue(MODE_ALLOC, '0);
        issue(MODE_RELEASE, '1);
        hold_until_drained();

        for (int n = 0; n < 700; n++) begin
            if (n % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            issue(pick_mode(), pick_id(focus));
        end

        quiet = 1'b1;
        issue(MODE_CLEAR_ALL, ID_W'($urandom()));
        issue(MODE_MARK, 16'h1234);
        issue(MODE_RELEASE, 16'h1234);
        issue(MODE_ALLOC, '0);
        issue(MODE_ALLOC, '0);
        issue(MODE_QUERY, 16'h1234);

        for (int n = 0; n < 700; n++) begin
            if (n % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                focus = ID_W'($urandom());
            end
            issue(pick_mode(), pick_id(focus));
        end

        quiet = 1'b1;
        for (int n = 0; n < 150; n++) begin
            if (n % 50 == 0) begin
                focus = ID_W'($urandom());
            end
            issue(pick_mode(), pick_id(focus));
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d commands of every mode and checked %0d results under stalls,",
                 cmd_count, result_count);
        $display("%0d full answers, %0d pointer wraps and %0d failures.",
                 full_count, wrap_count, fail_count + pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
